// ===== design/dqkp_pkg.sv =====
// shared constants for the deque with key purge: request and status codes
package dqkp_pkg;

	localparam int FUNC_W   = 3;
	localparam int STATUS_W = 2;

	localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_PURGE      = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd5;

	localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

endpackage

// ===== design/dqkp_store.sv =====
// ring store: one write port and two read ports with registered read data
module dqkp_store #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== design/deque_with_key_purge.sv =====
// top level of the deque with key purge: sequencer, ring pointers and purge walk
//
//  channel   | handshake          | fields
//  ----------+--------------------+-----------------------------------------------
//  request   | start, busy        | func, key_value
//  result    | done (one cycle)   | status, popped_key, purged_count, entry_count,
//            |                    | front_key, back_key
//
// push, pop, clear and unused codes pass from transfer to result through execute,
// read front and back, then the result cycle with done high.
// a purge runs execute, the walk over the held entries, then read and result: the walk reads one
// entry per cycle through the store's read port and compacts through its write port.
// reset clears the pointers and count; the store contents are not cleared.
// busy is high from the transfer until the result cycle ends; results cannot be stalled.
module deque_with_key_purge #(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [dqkp_pkg::FUNC_W-1:0]          func,
	input  logic signed [KEY_BITS-1:0]           key_value,
	output logic                                 done,
	output logic [dqkp_pkg::STATUS_W-1:0]        status,
	output logic signed [KEY_BITS-1:0]           popped_key,
	output logic [$clog2(CAPACITY+1)-1:0]        purged_count,
	output logic [$clog2(CAPACITY+1)-1:0]        entry_count,
	output logic signed [KEY_BITS-1:0]           front_key,
	output logic signed [KEY_BITS-1:0]           back_key
);

	import dqkp_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_PURGE = 3'd2;
	localparam logic [2:0] S_RD    = 3'd3;
	localparam logic [2:0] S_RESP  = 3'd4;

	logic [2:0]          state_q;
	logic [FUNC_W-1:0]   func_q;
	logic [KEY_BITS-1:0] key_q;
	logic [AW-1:0]       fp_q;
	logic [CW-1:0]       cnt_q;
	logic [STATUS_W-1:0] status_q;
	logic [KEY_BITS-1:0] popped_q;
	logic [CW-1:0]       purged_q;
	logic                pop_q;
	logic [AW-1:0]       rs_q;
	logic [AW-1:0]       ws_q;
	logic [CW-1:0]       left_q;
	logic [CW-1:0]       kept_q;
	logic                pv_q;

	logic [AW-1:0]       off_sel;
	logic [AW:0]         sum_raw;
	logic [AW-1:0]       slot;
	logic                full;
	logic                empty;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [KEY_BITS-1:0] ram_wdata;
	logic [AW-1:0]       ram_raddr_a;
	logic [AW-1:0]       ram_raddr_b;
	logic [KEY_BITS-1:0] ram_rdata_a;
	logic [KEY_BITS-1:0] ram_rdata_b;
	logic                keep;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] s);
		logic [AW-1:0] r;
		if (s == AW'(CAPACITY - 1)) begin
			r = '0;
		end else begin
			r = s + 1'b1;
		end
		return r;
	endfunction

	assign full  = (cnt_q == CW'(CAPACITY));
	assign empty = (cnt_q == '0);

	// shared ring index adder: front pointer plus an offset, modulo capacity
	always_comb begin
		off_sel = '0;
		if (state_q == S_RD) begin
			off_sel = AW'(cnt_q - 1'b1);
		end else begin
			case (func_q)
				FUNC_PUSH_FRONT: off_sel = AW'(CAPACITY - 1);
				FUNC_PUSH_BACK:  off_sel = cnt_q[AW-1:0];
				FUNC_POP_BACK:   off_sel = AW'(cnt_q - 1'b1);
				default:         off_sel = '0;
			endcase
		end
	end

	assign sum_raw = {1'b0, fp_q} + {1'b0, off_sel};
	assign slot    = (sum_raw >= (AW + 1)'(CAPACITY)) ?
		AW'(sum_raw - (AW + 1)'(CAPACITY)) : sum_raw[AW-1:0];

	assign keep = pv_q && (ram_rdata_a != key_q);

	always_comb begin
		ram_we      = 1'b0;
		ram_waddr   = slot;
		ram_wdata   = key_q;
		ram_raddr_a = slot;
		ram_raddr_b = slot;
		unique case (state_q)
			S_EXEC: begin
				ram_we = ((func_q == FUNC_PUSH_FRONT) || (func_q == FUNC_PUSH_BACK)) && !full;
			end
			S_PURGE: begin
				ram_raddr_a = rs_q;
				ram_we      = keep;
				ram_waddr   = ws_q;
				ram_wdata   = ram_rdata_a;
			end
			S_RD: begin
				ram_raddr_a = fp_q;
			end
			default: begin
			end
		endcase
	end

	dqkp_store #(
		.DEPTH(CAPACITY),
		.WIDTH(KEY_BITS)
	) u_store (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (ram_rdata_a),
		.rdata_b (ram_rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fp_q    <= '0;
			cnt_q   <= '0;
			pv_q    <= 1'b0;
			left_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= (func_q == FUNC_PURGE) ? S_PURGE : S_RD;
					unique case (func_q)
						FUNC_PUSH_FRONT: begin
							if (!full) begin
								fp_q  <= slot;
								cnt_q <= cnt_q + 1'b1;
							end
						end
						FUNC_PUSH_BACK: begin
							if (!full) begin
								cnt_q <= cnt_q + 1'b1;
							end
						end
						FUNC_POP_FRONT: begin
							if (!empty) begin
								fp_q  <= wrap_inc(fp_q);
								cnt_q <= cnt_q - 1'b1;
							end
						end
						FUNC_POP_BACK: begin
							if (!empty) begin
								cnt_q <= cnt_q - 1'b1;
							end
						end
						FUNC_PURGE: begin
							left_q  <= cnt_q;
							pv_q    <= 1'b0;
						end
						FUNC_CLEAR: begin
							cnt_q <= '0;
						end
						default: begin
						end
					endcase
				end
				S_PURGE: begin
					if (left_q != '0) begin
						left_q <= left_q - 1'b1;
						pv_q   <= 1'b1;
					end else begin
						pv_q <= 1'b0;
						if (!pv_q) begin
							cnt_q   <= kept_q;
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				func_q <= func;
				key_q  <= key_value;
			end
			S_EXEC: begin
				popped_q <= '0;
				rs_q     <= fp_q;
				ws_q     <= fp_q;
				kept_q   <= '0;
				unique case (func_q) inside
					FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
						status_q <= full ? STATUS_FULL : STATUS_DONE;
						purged_q <= '0;
						pop_q    <= 1'b0;
					end
					FUNC_POP_FRONT, FUNC_POP_BACK: begin
						status_q <= empty ? STATUS_EMPTY : STATUS_DONE;
						purged_q <= '0;
						pop_q    <= !empty;
					end
					FUNC_CLEAR: begin
						status_q <= STATUS_DONE;
						purged_q <= cnt_q;
						pop_q    <= 1'b0;
					end
					default: begin
						status_q <= STATUS_DONE;
						purged_q <= '0;
						pop_q    <= 1'b0;
					end
				endcase
			end
			S_PURGE: begin
				if (left_q != '0) begin
					rs_q <= wrap_inc(rs_q);
				end
				if (keep) begin
					ws_q   <= wrap_inc(ws_q);
					kept_q <= kept_q + 1'b1;
				end
				if ((left_q == '0) && !pv_q) begin
					purged_q <= cnt_q - kept_q;
				end
			end
			S_RD: begin
				if (pop_q) begin
					popped_q <= ram_rdata_a;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = (state_q == S_RESP);
	assign status       = status_q;
	assign popped_key   = popped_q;
	assign purged_count = purged_q;
	assign entry_count  = cnt_q;
	assign front_key    = empty ? '0 : ram_rdata_a;
	assign back_key     = empty ? '0 : ram_rdata_b;

endmodule
